// ----- design/picnt_pkg.sv -----
// ----------------------------------------------------------------------------
// picnt_pkg: shared types for the per-protocol IP request counter table
// Holds the result status codes, the controller state type, the command and
// status bundles between controller and datapath, and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package picnt_pkg;

	localparam int ADDR_W  = 32;
	localparam int PROTO_W = 2;
	localparam int DELTA_W = 8;
	localparam int LIMIT_W = 16;
	localparam int OCNT_W  = 16;

	localparam logic [LIMIT_W-1:0] LOW_LIMIT_RESET = 16'hFFF0;

	typedef enum logic [1:0] {
		STAT_UPDATED  = 2'd0,
		STAT_INSERTED = 2'd1,
		STAT_DROPPED  = 2'd2,
		STAT_FULL     = 2'd3
	} picnt_status_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_LOOKUP = 2'd1,
		ST_UPDATE = 2'd2
	} picnt_state_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic commit;
	} picnt_cmd_t;

	typedef struct packed {
		logic out_stall;
	} picnt_stat_t;

endpackage

`default_nettype wire

// ----- design/picnt_ram.sv -----
// ----------------------------------------------------------------------------
// picnt_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered and holds
// while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module picnt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- design/picnt_ctrl.sv -----
// ----------------------------------------------------------------------------
// picnt_ctrl: sequencing of one request through the counter table
// Steps each request through accept, lookup and update, holding the update
// while the result register is still occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module picnt_ctrl
	import picnt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire picnt_stat_t stat,
	output      picnt_cmd_t  cmd
);

	picnt_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (!stat.out_stall) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- design/picnt_dp.sv -----
// ----------------------------------------------------------------------------
// picnt_dp: counter table datapath
// Tag store with parallel match, priority encoders, count RAM with
// saturating update, low limit register and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module picnt_dp
	import picnt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 64,
	parameter int COUNT_BITS    = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire picnt_cmd_t         cmd,
	output      picnt_stat_t        stat,
	input  wire logic [ADDR_W-1:0]  in_addr,
	input  wire logic [PROTO_W-1:0] in_proto,
	input  wire logic [DELTA_W-1:0] in_delta,
	input  wire logic               limit_we,
	input  wire logic [LIMIT_W-1:0] limit_wdata,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic [1:0]         out_status,
	output      logic [OCNT_W-1:0]  out_count,
	output      logic               out_warn
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int SUM_W = COUNT_BITS + 1;
	// Wide enough for any count width and the 16-bit limit, with sign.
	localparam int CMP_W = ((COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W) + 1;

	// Tag store: each entry compared in parallel against the key.
	logic               valid_q [TABLE_ENTRIES];
	logic [PROTO_W-1:0] proto_q [TABLE_ENTRIES];
	logic [ADDR_W-1:0]  addr_q  [TABLE_ENTRIES];

	logic [LIMIT_W-1:0] low_limit_q;

	logic [ADDR_W-1:0]        key_addr_s1;
	logic [PROTO_W-1:0]       key_proto_s1;
	logic signed [DELTA_W-1:0] delta_s1;
	logic [TABLE_ENTRIES-1:0] match_s1;
	logic [TABLE_ENTRIES-1:0] free_s1;

	logic             hit_s2;
	logic             free_ok_s2;
	logic [IDX_W-1:0] hit_idx_s2;
	logic [IDX_W-1:0] free_idx_s2;

	logic [IDX_W-1:0] hit_idx;
	logic [IDX_W-1:0] free_idx;

	logic                    out_valid_q;
	logic [1:0]              out_status_q;
	logic [OCNT_W-1:0]       out_count_q;
	logic                    out_warn_q;

	logic [COUNT_BITS-1:0]          rd_count;
	logic signed [COUNT_BITS-1:0]   base;
	logic signed [SUM_W-1:0]        sum;
	logic signed [COUNT_BITS-1:0]   new_count;
	logic signed [CMP_W-1:0]        count_ext;
	logic signed [CMP_W-1:0]        limit_ext;
	logic                           drop;
	logic                           ram_we;
	logic [IDX_W-1:0]               ram_waddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q <= LOW_LIMIT_RESET;
		end else if (limit_we) begin
			low_limit_q <= limit_wdata;
		end
	end

	// Key capture and parallel compare against the current tags.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_addr_s1  <= in_addr;
			key_proto_s1 <= in_proto;
			delta_s1     <= in_delta;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				match_s1[i] <= valid_q[i] && (proto_q[i] == in_proto) &&
				               (addr_q[i] == in_addr);
				free_s1[i]  <= !valid_q[i];
			end
		end
	end

	// Lowest set bit wins in both vectors.
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (free_s1[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_s2      <= |match_s1;
			free_ok_s2  <= |free_s1;
			hit_idx_s2  <= hit_idx;
			free_idx_s2 <= free_idx;
		end
	end

	// An insertion starts from zero, so the same adder serves both cases.
	always_comb begin
		base      = hit_s2 ? signed'(rd_count) : '0;
		sum       = SUM_W'(base) + SUM_W'(delta_s1);
		if (sum[SUM_W-1] != sum[SUM_W-2]) begin
			new_count = sum[SUM_W-1] ? {1'b1, {(COUNT_BITS-1){1'b0}}}
			                         : {1'b0, {(COUNT_BITS-1){1'b1}}};
		end else begin
			new_count = sum[COUNT_BITS-1:0];
		end
		count_ext = CMP_W'(new_count);
		limit_ext = CMP_W'(signed'(low_limit_q));
		drop      = hit_s2 && ((new_count == '0) || (count_ext < limit_ext));
		ram_we    = cmd.commit && (hit_s2 ? !drop : free_ok_s2);
		ram_waddr = hit_s2 ? hit_idx_s2 : free_idx_s2;
	end

	picnt_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (TABLE_ENTRIES)
	) u_count_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (new_count),
		.re    (cmd.lookup),
		.raddr (hit_idx),
		.rdata (rd_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (cmd.commit) begin
			if (hit_s2) begin
				if (drop) begin
					valid_q[hit_idx_s2] <= 1'b0;
				end
			end else if (free_ok_s2) begin
				valid_q[free_idx_s2] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && !hit_s2 && free_ok_s2) begin
			proto_q[free_idx_s2] <= key_proto_s1;
			addr_q[free_idx_s2]  <= key_addr_s1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (hit_s2 && drop) begin
				out_status_q <= STAT_DROPPED;
				out_count_q  <= '0;
				out_warn_q   <= 1'b0;
			end else if (hit_s2 || free_ok_s2) begin
				out_status_q <= hit_s2 ? STAT_UPDATED : STAT_INSERTED;
				out_count_q  <= count_ext[OCNT_W-1:0];
				out_warn_q   <= new_count[COUNT_BITS-1];
			end else begin
				out_status_q <= STAT_FULL;
				out_count_q  <= '0;
				out_warn_q   <= 1'b0;
			end
		end
	end

	assign stat.out_stall = out_valid_q && !out_ready;
	assign out_valid      = out_valid_q;
	assign out_status     = out_status_q;
	assign out_count      = out_count_q;
	assign out_warn       = out_warn_q;

endmodule

`default_nettype wire

// ----- design/per_protocol_ip_request_counter_table.sv -----
// Each request passes through the steps accept with tag match, encode with count read
// and count update, set by the registered match and registered count read; a new
// request is accepted only after the update step of the one before it.
// A pending result that is not taken holds the update step.
// Reset clears all entry valid bits at once and loads low_limit with -16.
// ----------------------------------------------------------------------------
// per_protocol_ip_request_counter_table: per-host request/response counter
// Matches protocol and IPv4 address, adds a signed delta with saturation,
// inserts unknown hosts while a free entry remains and drops entries at zero or below the low limit.
// ----------------------------------------------------------------------------
`default_nettype none

module per_protocol_ip_request_counter_table
	import picnt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 64,
	parameter int COUNT_BITS    = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // ip_addr[31:0], proto_index[33:32], delta[41:34]
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [15:0] m_axis_tdata,  // count[15:0]
	output      logic [2:0]  m_axis_tuser,  // status[1:0], negative_warning[2]
	input  wire logic        low_limit_we,
	input  wire logic [15:0] low_limit_wdata
);

	picnt_cmd_t  cmd;
	picnt_stat_t stat;
	logic [1:0]  out_status;
	logic        out_warn;

	picnt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	picnt_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.COUNT_BITS    (COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_addr     (s_axis_tdata[31:0]),
		.in_proto    (s_axis_tdata[33:32]),
		.in_delta    (s_axis_tdata[41:34]),
		.limit_we    (low_limit_we),
		.limit_wdata (low_limit_wdata),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_status  (out_status),
		.out_count   (m_axis_tdata),
		.out_warn    (out_warn)
	);

	assign m_axis_tuser = {out_warn, out_status};

endmodule

`default_nettype wire
